>>> src/stwq_pkg.sv
// ----------------------------------------------------------------------------
// stwq_pkg
// Shared types and constants for the semaphore table with wait queues.
// ----------------------------------------------------------------------------
package stwq_pkg;

  localparam int CountW = 16;
  localparam int InitW  = 15;
  localparam int PidW   = 8;
  localparam int SemW   = 4;

  localparam logic signed [CountW-1:0] CountMax = 16'sh7FFF;
  localparam logic signed [CountW-1:0] CountMin = 16'sh8000;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_WAIT   = 2'd1,
    CMD_SIGNAL = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFREE   = 2'd1,
    ST_QFULL    = 2'd2,
    ST_NOTALLOC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_BLOCK   = 2'd1,
    ACT_UNBLOCK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_HOLD
  } state_e;

  // decision for one request, from the entry read back
  typedef struct packed {
    logic                     ent_wr;
    logic                     alloc_take;
    logic                     q_push;
    logic                     q_pop;
    logic                     tgt_pid;
    status_e                  status;
    action_e                  action;
    logic signed [CountW-1:0] count_new;
  } dec_t;

  typedef struct packed {
    logic [SemW-1:0] alloc_index;
    status_e         status;
    action_e         action;
    logic [PidW-1:0] target_process;
  } rsp_t;

endpackage

>>> src/stwq_if.sv
// ----------------------------------------------------------------------------
// stwq request and response channels
// Valid/ready channels carrying one request and one response.
// ----------------------------------------------------------------------------
interface stwq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  process_id;
  logic [3:0]  sem_index;
  logic [14:0] init_value;

  modport source (output valid, cmd, process_id, sem_index, init_value, input ready);
  modport sink   (input valid, cmd, process_id, sem_index, init_value, output ready);
endinterface

interface stwq_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] alloc_index;
  logic [1:0] status;
  logic [1:0] action;
  logic [7:0] target_process;

  modport source (output valid, alloc_index, status, action, target_process, input ready);
  modport sink   (input valid, alloc_index, status, action, target_process, output ready);
endinterface

>>> src/semaphore_table_with_wait_queues_top.sv
// ----------------------------------------------------------------------------
// semaphore_table_with_wait_queues_top
// Table of counting semaphores, each with a ring of blocked process ids.
// ----------------------------------------------------------------------------
// One request is handled at a time. For allocate, wait and a signal that
// finds an empty queue, the semaphore entry memory is read at acceptance,
// then the decision state decides and writes it back. A signal that
// dequeues reads the queue memory after that, since the queue slot address
// needs the ring head read from the entry memory first. A stalled response
// port holds the result back until the output register frees up; the
// next request can be accepted while a finished response waits there.
// Entries are handed out in order and never released, so the lowest free
// entry is a fill count and no clearing pass is needed after reset.
module semaphore_table_with_wait_queues_top import stwq_pkg::*; #(
  parameter int NUM_SEMS  = 16,
  parameter int NUM_PROCS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stwq_req_if.sink   req_i,
  stwq_rsp_if.source rsp_o
);

  localparam int SW  = $clog2(NUM_SEMS);
  localparam int AW  = $clog2(NUM_SEMS + 1);
  localparam int CW  = (AW > SemW) ? AW : SemW;
  localparam int PW  = $clog2(NUM_PROCS);
  localparam int LW  = $clog2(NUM_PROCS + 1);
  localparam int QD  = NUM_SEMS * NUM_PROCS;
  localparam int QAW = $clog2(QD);

  // one semaphore entry: count plus ring state
  typedef struct packed {
    logic signed [CountW-1:0] count;
    logic [PW-1:0]            head;
    logic [LW-1:0]            len;
  } ent_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [PidW-1:0] pid;
    logic [SemW-1:0] sem;
    logic [InitW-1:0] init;
  } req_t;

  state_e state_q, state_d;
  req_t   req_q;
  logic [AW-1:0] alloc_cnt_q;

  // entry memory and queue memory
  ent_t            ent_mem [NUM_SEMS];
  ent_t            ent_rd_q;
  logic [PidW-1:0] q_mem [QD];
  logic [PidW-1:0] q_rd_q;

  logic out_valid_q;
  rsp_t out_q;
  rsp_t res_q, res_d, res_exec;

  logic req_fire, rsp_fire, out_free;
  logic entry_ok, alloc_full;
  dec_t dec;

  logic            ent_we;
  logic [SW-1:0]   ent_waddr;
  ent_t            ent_wdata;
  logic            q_we, q_re, ld_out;
  logic [LW:0]     tail_sum;
  logic [PW-1:0]   tail_slot, head_next;
  logic [QAW-1:0]  q_base, q_waddr, q_raddr;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // entries below the fill count are allocated
  assign entry_ok   = CW'(req_q.sem) < CW'(alloc_cnt_q);
  assign alloc_full = (alloc_cnt_q == AW'(NUM_SEMS));

  stwq_decide u_decide (
    .cmd_i        (req_q.cmd),
    .entry_ok_i   (entry_ok),
    .alloc_full_i (alloc_full),
    .q_full_i     (ent_rd_q.len == LW'(NUM_PROCS)),
    .q_empty_i    (ent_rd_q.len == '0),
    .count_i      (ent_rd_q.count),
    .init_i       (req_q.init),
    .dec_o        (dec)
  );

  // ring arithmetic, tail only used when the ring is not full
  assign tail_sum  = (LW + 1)'(ent_rd_q.head) + (LW + 1)'(ent_rd_q.len);
  assign tail_slot = (tail_sum >= (LW + 1)'(NUM_PROCS)) ?
                     PW'(tail_sum - (LW + 1)'(NUM_PROCS)) : PW'(tail_sum);
  assign head_next = (LW'(ent_rd_q.head) == LW'(NUM_PROCS - 1)) ?
                     '0 : ent_rd_q.head + PW'(1);

  assign q_base  = QAW'(SW'(req_q.sem)) * QAW'(NUM_PROCS);
  assign q_waddr = q_base + QAW'(tail_slot);
  assign q_raddr = q_base + QAW'(ent_rd_q.head);

  // write-back of the entry
  always_comb begin
    ent_waddr = dec.alloc_take ? SW'(alloc_cnt_q) : SW'(req_q.sem);
    ent_wdata.count = dec.count_new;
    if (dec.alloc_take) begin
      ent_wdata.head = '0;
      ent_wdata.len  = '0;
    end else if (dec.q_pop) begin
      ent_wdata.head = head_next;
      ent_wdata.len  = ent_rd_q.len - LW'(1);
    end else begin
      ent_wdata.head = ent_rd_q.head;
      ent_wdata.len  = ent_rd_q.len + LW'(dec.q_push);
    end
  end

  // result as known right after the decision
  always_comb begin
    res_exec.alloc_index    = dec.alloc_take ? SemW'(alloc_cnt_q) : '0;
    res_exec.status         = dec.status;
    res_exec.action         = dec.action;
    res_exec.target_process = dec.tgt_pid ? req_q.pid : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (dec.q_pop)     state_d = S_POP;
        else if (out_free) state_d = S_IDLE;
        else               state_d = S_HOLD;
      end
      S_POP: begin
        state_d = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ent_we = 1'b0;
    q_we   = 1'b0;
    q_re   = 1'b0;
    ld_out = 1'b0;
    res_d  = res_q;
    case (state_q)
      S_EXEC: begin
        ent_we = dec.ent_wr;
        q_we   = dec.q_push;
        q_re   = dec.q_pop;
        ld_out = out_free && !dec.q_pop;
        res_d  = res_exec;
      end
      S_POP: begin
        ld_out = out_free;
        res_d.target_process = q_rd_q;
      end
      S_HOLD: begin
        ld_out = out_free;
      end
      default: begin
        ld_out = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alloc_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC && dec.alloc_take) alloc_cnt_q <= alloc_cnt_q + AW'(1);
      if (ld_out)        out_valid_q <= 1'b1;
      else if (rsp_fire) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q.cmd  <= req_i.cmd;
      req_q.pid  <= req_i.process_id;
      req_q.sem  <= req_i.sem_index;
      req_q.init <= req_i.init_value;
    end
    res_q <= res_d;
    if (ld_out) out_q <= res_d;
  end

  // entry memory: read at acceptance, written back after the decision
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (req_fire) ent_rd_q <= ent_mem[SW'(req_i.sem_index)];
  end

  // queue memory: push on blocking wait, read on dequeuing signal
  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_waddr] <= req_q.pid;
    if (q_re) q_rd_q <= q_mem[q_raddr];
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.alloc_index    = out_q.alloc_index;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.action         = out_q.action;
  assign rsp_o.target_process = out_q.target_process;

  // an accepted request always goes to the decision cycle
  a_fire_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == S_EXEC)
    else $error("accepted request did not reach decision");

  // never push into a full ring
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && dec.q_push) |-> ent_rd_q.len != LW'(NUM_PROCS))
    else $error("push into full wait queue");

  // fill count stays within the table
  a_alloc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_cnt_q <= AW'(NUM_SEMS))
    else $error("allocation count beyond table");

  // a response appears only after a request was worked on
  a_rsp_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) != S_IDLE)
    else $error("response without request");

endmodule

>>> src/stwq_decide.sv
// ----------------------------------------------------------------------------
// stwq_decide
// Works out the count update, queue move and result of one request.
// ----------------------------------------------------------------------------
module stwq_decide import stwq_pkg::*; (
  input  logic [1:0]               cmd_i,
  input  logic                     entry_ok_i,
  input  logic                     alloc_full_i,
  input  logic                     q_full_i,
  input  logic                     q_empty_i,
  input  logic signed [CountW-1:0] count_i,
  input  logic [InitW-1:0]         init_i,
  output dec_t                     dec_o
);

  logic signed [CountW-1:0] count_dec;
  logic signed [CountW-1:0] count_inc;

  // saturating step
  assign count_dec = (count_i == CountMin) ? count_i : count_i - 16'sd1;
  assign count_inc = (count_i == CountMax) ? count_i : count_i + 16'sd1;

  always_comb begin
    dec_o = '0;
    dec_o.status = ST_OK;
    dec_o.action = ACT_NONE;
    case (cmd_e'(cmd_i))
      CMD_ALLOC: begin
        dec_o.count_new = {1'b0, init_i};
        if (alloc_full_i) begin
          dec_o.status = ST_NOFREE;
        end else begin
          dec_o.ent_wr     = 1'b1;
          dec_o.alloc_take = 1'b1;
        end
      end
      CMD_WAIT: begin
        if (!entry_ok_i) begin
          dec_o.status = ST_NOTALLOC;
        end else begin
          dec_o.ent_wr    = 1'b1;
          dec_o.count_new = count_dec;
          if (count_dec[CountW-1]) begin
            dec_o.action  = ACT_BLOCK;
            dec_o.tgt_pid = 1'b1;
            if (q_full_i) begin
              dec_o.status = ST_QFULL;
            end else begin
              dec_o.q_push = 1'b1;
            end
          end
        end
      end
      CMD_SIGNAL: begin
        if (!entry_ok_i) begin
          dec_o.status = ST_NOTALLOC;
        end else begin
          dec_o.ent_wr    = 1'b1;
          dec_o.count_new = count_inc;
          if (!q_empty_i) begin
            dec_o.q_pop  = 1'b1;
            dec_o.action = ACT_UNBLOCK;
          end
        end
      end
      default: begin
        dec_o.status = ST_OK;
      end
    endcase
  end

endmodule
